>>> rtl/pee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pee_pkg
// Shared codes and controller/datapath interface types for the postfix
// evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int DATA_W = 32;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_ZERODIV = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_UNDER   = 3'd4;
    localparam logic [2:0] ST_OVER    = 3'd5;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // character classes
    localparam logic [2:0] CC_DIGIT = 3'd0;
    localparam logic [2:0] CC_SPACE = 3'd1;
    localparam logic [2:0] CC_NL    = 3'd2;
    localparam logic [2:0] CC_OP    = 3'd3;
    localparam logic [2:0] CC_OTHER = 3'd4;

    typedef struct packed {
        logic       load_char;
        logic       acc_digit;
        logic       push;
        logic       clear_count;
        logic       rd_en;
        logic       div_start;
        logic       alu_write;
        logic       out_load;
        logic       out_from_tos;
        logic [2:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       is_div;
        logic       in_number;
        logic       count_zero;
        logic       count_one;
        logic       count_lt2;
        logic       full;
        logic       tos_zero;
        logic       div_done;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/pee_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pee_ctrl
// Sequencer: takes one character, steps the datapath through push, operator
// and report, and holds the halt flag after an error.
// ----------------------------------------------------------------------------
module pee_ctrl
    import pee_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_EXEC     = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       halted_reg, halted_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        halted_next = halted_reg;
        cmd         = '0;
        cmd.out_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_char = 1'b1;
                    if (!halted_reg)
                        state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.cls == CC_DIGIT)
                begin
                    cmd.acc_digit = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.in_number && sts.full)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OVER;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.push   = sts.in_number;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_OUT;
                cmd.out_load = 1'b1;
                unique case (sts.cls)
                    CC_SPACE:
                    begin
                        cmd.out_load = 1'b0;
                        state_next   = S_IDLE;
                    end
                    CC_NL:
                    begin
                        if (sts.count_one)
                        begin
                            cmd.out_from_tos = 1'b1;
                            cmd.clear_count  = 1'b1;
                        end
                        else
                            cmd.out_status = ST_INVALID;
                    end
                    CC_OP:
                    begin
                        priority if (sts.count_zero)
                            cmd.out_status = ST_UNDER;
                        else if (sts.is_div && sts.tos_zero)
                            cmd.out_status = ST_ZERODIV;
                        else if (sts.count_lt2)
                            cmd.out_status = ST_UNDER;
                        else
                        begin
                            cmd.out_load = 1'b0;
                            cmd.rd_en    = 1'b1;
                            state_next   = S_EXEC;
                        end
                    end
                    default:
                        cmd.out_status = ST_UNKNOWN;
                endcase
            end
            S_EXEC:
            begin
                if (sts.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.alu_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.alu_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cmd.out_load && (cmd.out_status != ST_OK))
            halted_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
        end
    end

    // once halted, no character is processed any more
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (state_reg == S_IDLE || state_reg == S_OUT))
        else $error("halted block left idle");

    // an error always comes with a reported transaction
    a_halt_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> out_valid)
        else $error("halt without error report");

    // a taken result returns the sequencer to idle
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (state_reg == S_IDLE))
        else $error("result taken but sequencer not idle");

endmodule
`default_nettype wire

>>> rtl/pee_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pee_dp
// Datapath: character register, digit accumulator, operand stack with the top
// entry cached, adder/multiplier, iterative divider and result register.
// ----------------------------------------------------------------------------
module pee_dp
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        char_in,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic signed [DATA_W-1:0] result_value,
    output logic [2:0]             status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

    logic [7:0]        char_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              in_number_reg, in_number_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [CW-1:0]     count_m1, count_m2;
    logic              wr_en;
    logic [DATA_W-1:0] result_reg;
    logic [2:0]        status_reg;
    logic [2:0]        cls;

    // divider; the remainder stays below the divisor magnitude, so 32 bits hold it
    logic [DATA_W-1:0] div_rem_reg;
    logic [DATA_W-1:0] div_quo_reg, div_den_reg;
    logic [4:0]        div_cnt_reg;
    logic              div_busy_reg, div_done_reg, div_neg_reg;
    logic [DATA_W:0]   div_shift, div_diff;
    logic              div_bit;

    logic [DATA_W-1:0] lhs, rhs, mul_res, alu_res, quo_signed;

    assign lhs = rd_data_reg;
    assign rhs = tos_reg;

    always_comb
    begin
        priority if (char_reg >= CH_ZERO && char_reg <= CH_NINE)
            cls = CC_DIGIT;
        else if (char_reg == CH_SPACE || char_reg == CH_TAB || char_reg == CH_VT ||
                 char_reg == CH_FF || char_reg == CH_CR)
            cls = CC_SPACE;
        else if (char_reg == CH_NL)
            cls = CC_NL;
        else if (char_reg == CH_PLUS || char_reg == CH_MINUS || char_reg == CH_STAR ||
                 char_reg == CH_SLASH)
            cls = CC_OP;
        else
            cls = CC_OTHER;
    end

    assign sts.cls        = cls;
    assign sts.is_div     = (char_reg == CH_SLASH);
    assign sts.in_number  = in_number_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.count_lt2  = (count_reg < CW'(2));
    assign sts.full       = (count_reg == COUNT_FULL);
    assign sts.tos_zero   = (tos_reg == '0);
    assign sts.div_done   = div_done_reg;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign wr_en    = cmd.push && (count_reg != '0);

    // arithmetic
    assign mul_res    = lhs * rhs;
    assign quo_signed = div_neg_reg ? (DATA_W'(0) - div_quo_reg) : div_quo_reg;

    always_comb
    begin
        unique case (char_reg)
            CH_PLUS:  alu_res = lhs + rhs;
            CH_MINUS: alu_res = lhs - rhs;
            CH_STAR:  alu_res = mul_res;
            default:  alu_res = quo_signed;
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        in_number_next = in_number_reg;
        count_next     = count_reg;
        tos_next       = tos_reg;
        if (cmd.acc_digit)
        begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) + {28'd0, char_reg[3:0]};
            in_number_next = 1'b1;
        end
        if (cmd.push)
        begin
            tos_next       = acc_reg;
            count_next     = count_reg + CW'(1);
            acc_next       = '0;
            in_number_next = 1'b0;
        end
        if (cmd.alu_write)
        begin
            tos_next   = alu_res;
            count_next = count_m1;
        end
        if (cmd.clear_count)
            count_next = '0;
    end

    // restoring division step on magnitudes
    assign div_shift = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign div_bit   = !div_diff[DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            in_number_reg <= 1'b0;
            count_reg     <= '0;
            div_busy_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            acc_reg       <= acc_next;
            in_number_reg <= in_number_next;
            count_reg     <= count_next;
            div_done_reg  <= div_busy_reg && (div_cnt_reg == 5'd31);
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                    div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.load_char)
            char_reg <= char_in;
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
            div_den_reg <= rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
            div_neg_reg <= lhs[DATA_W-1] ^ rhs[DATA_W-1];
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_bit ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
            div_quo_reg <= {div_quo_reg[DATA_W-2:0], div_bit};
        end
        if (cmd.out_load)
        begin
            result_reg <= cmd.out_from_tos ? tos_reg : '0;
            status_reg <= cmd.out_status;
        end
    end

    // entries below the top; the top itself lives in tos_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[count_m1[AW-1:0]] <= tos_reg;
        if (cmd.rd_en)
            rd_data_reg <= stack_mem[count_m2[AW-1:0]];
    end

    assign result_value = signed'(result_reg);
    assign status       = status_reg;

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alu_write |-> (count_reg >= CW'(2)))
        else $error("operator result written with fewer than two entries");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < COUNT_FULL))
        else $error("push onto a full stack");

    // a new division never starts while one is still running
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy_reg)
        else $error("division started while divider busy");

endmodule
`default_nettype wire

>>> rtl/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish integer evaluator fed one character per transaction.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with char_in, one ASCII character per
// transaction. Output channel: out_valid / out_stall with result_value and
// status; a transaction is produced for every newline and for every error.
//
// Characters are handled one at a time by a sequencer; in_stall is high
// while a character is in progress or a result waits to be taken.
//   digit: accumulator x10 + digit by shift-and-add
//   space class: decode, then dispatch; newline: decode, dispatch, then out_valid
//   + - *: second operand read from the stack memory, then through the adder
//          or the 32x32 multiplier
//   /: radix-2 restoring divider (32 steps)
// A character that ends a digit run pushes the number first, while it is decoded.
// The top of stack is held in a register; lower entries sit in a memory of
// STACK_DEPTH words with one write and one registered read port.
//
// Reset clears the stack count, the accumulator and the halt flag; stack
// memory is not cleared. While the receiver stalls, the result is held and
// no further character is taken. After an error status the block keeps
// taking characters but ignores them and reports nothing until reset.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            char_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [DATA_W-1:0]   result_value,
    output logic [2:0]                 status
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: handshakes, character flow, halt flag
    pee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: stack, arithmetic, result register
    pee_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .cmd          (cmd),
        .sts          (sts),
        .result_value (result_value),
        .status       (status)
    );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix evaluator. A short directed stream is
// sent first, then randomly built well-formed expression lines, then one
// halting fault and a stream of ignored characters. Results are checked in
// order against a predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import pee_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_CHARS = 1700;
    localparam int TAIL_CHARS   = 40;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum {PACE_STEADY, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

    // ------------------------------------------------------------------------
    // Predictor plus ordered store of expected result transactions.
    // ------------------------------------------------------------------------
    class postfix_tracker;
        logic [31:0] stk [STACK_DEPTH];
        int          depth;
        logic [31:0] acc;
        bit          in_num;
        bit          halted;
        logic [31:0] want_value [$];
        logic [2:0]  want_status [$];
        int          errors;
        int          n_chars;
        int          n_results;
        logic [2:0]  halt_status;

        function new();
            depth = 0;
            acc = '0;
            in_num = 0;
            halted = 0;
            errors = 0;
            n_chars = 0;
            n_results = 0;
            halt_status = ST_OK;
        endfunction

        function void expect_result(logic [31:0] v, logic [2:0] st);
            want_value.push_back(v);
            want_status.push_back(st);
            if (st != ST_OK)
            begin
                halted = 1;
                halt_status = st;
            end
        endfunction

        // truncating signed divide done on magnitudes, so MIN / -1 wraps
        function logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? (32'd0 - a) : a;
            mb = b[31] ? (32'd0 - b) : b;
            q = ma / mb;
            return (a[31] ^ b[31]) ? (32'd0 - q) : q;
        endfunction

        // divisor that a slash would see right now
        function logic [31:0] divisor();
            if (in_num)
                return acc;
            if (depth > 0)
                return stk[depth - 1];
            return '0;
        endfunction

        function void take_char(logic [7:0] c);
            logic [31:0] lhs;
            logic [31:0] rhs;
            logic [31:0] res;
            n_chars++;
            if (halted)
                return;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
                in_num = 1;
                return;
            end
            if (in_num)
            begin
                if (depth >= STACK_DEPTH)
                begin
                    expect_result('0, ST_OVER);
                    return;
                end
                stk[depth] = acc;
                depth++;
                acc = '0;
                in_num = 0;
            end
            case (c)
                CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
                CH_NL:
                begin
                    if (depth == 1)
                    begin
                        depth = 0;
                        expect_result(stk[0], ST_OK);
                    end
                    else
                        expect_result('0, ST_INVALID);
                end
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                begin
                    if (depth == 0)
                        expect_result('0, ST_UNDER);
                    else if (c == CH_SLASH && stk[depth - 1] == '0)
                        expect_result('0, ST_ZERODIV);
                    else if (depth < 2)
                        expect_result('0, ST_UNDER);
                    else
                    begin
                        rhs = stk[depth - 1];
                        lhs = stk[depth - 2];
                        case (c)
                            CH_PLUS:  res = lhs + rhs;
                            CH_MINUS: res = lhs - rhs;
                            CH_STAR:  res = lhs * rhs;
                            default:  res = quot_trunc(lhs, rhs);
                        endcase
                        depth--;
                        stk[depth - 1] = res;
                    end
                end
                default: expect_result('0, ST_UNKNOWN);
            endcase
        endfunction

        function void match_result(logic [31:0] v, logic [2:0] st);
            logic [31:0] ev;
            logic [2:0]  es;
            n_results++;
            if (want_value.size() == 0)
            begin
                $display("%0t: result with nothing expected: value %0d status %0d",
                         $time, $signed(v), st);
                errors++;
                return;
            end
            ev = want_value.pop_front();
            es = want_status.pop_front();
            if (v !== ev)
            begin
                $display("%0t: result_value mismatch: expected %0d, got %0d",
                         $time, $signed(ev), $signed(v));
                errors++;
            end
            if (st !== es)
            begin
                $display("%0t: status mismatch: expected %0d, got %0d", $time, es, st);
                errors++;
            end
        endfunction

        function int pending();
            return want_value.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_in = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic [2:0]  status;

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;

    postfix_tracker sb = new();

    logic [7:0] blanks [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    logic [7:0] ops [4]    = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    always #10 clk = ~clk;

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL postfix_expression_evaluator");
            $finish;
        end
    end

    // Receiver back-pressure, rate set by the current pacing phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Output monitor: values sampled at the edge, before the DUT updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_result(result_value, status);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    task automatic set_pace(pace_t p);
        case (p)
            PACE_STEADY:      begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_GAPS:   begin send_gap_pct = 63; recv_stall_pct = 0;  end
            PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 63; end
            default:          begin send_gap_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    // One transaction on the input channel. Called at a rising edge; returns
    // at the edge where the character was taken, so valid is only ever
    // assigned once per step.
    task automatic send_char(logic [7:0] c);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_char(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_blanks(int n);
        for (int i = 0; i < n; i++)
            send_char(blanks[$urandom_range(0, 4)]);
    endtask

    // Number text: mostly short, sometimes full 32-bit, leading zeros, or a
    // digit run long enough to wrap.
    task automatic send_number();
        int form;
        int len;
        form = $urandom_range(0, 9);
        if (form <= 4)
            send_text($sformatf("%0d", $urandom_range(0, 9)));
        else if (form <= 6)
            send_text($sformatf("%0d", $urandom_range(0, 999)));
        else if (form == 7)
            send_text($sformatf("%0d", $urandom()));
        else if (form == 8)
            send_text($sformatf("00%0d", $urandom_range(0, 99)));
        else
        begin
            len = $urandom_range(10, 13);
            for (int i = 0; i < len; i++)
                send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // Operator; a slash that would meet a zero divisor is swapped out so the
    // line stays well formed.
    task automatic send_operator();
        logic [7:0] op;
        op = ops[$urandom_range(0, 3)];
        if (op == CH_SLASH && sb.divisor() == '0)
            op = ops[$urandom_range(0, 2)];
        send_char(op);
    endtask

    // One well-formed expression line ending in a newline. Deep lines push
    // everything first, up to a completely full stack, then fold it down.
    task automatic send_line();
        bit deep;
        int maxd;
        int target;
        int d;
        int pushed;
        bit prev_num;
        deep = ($urandom_range(0, 11) == 0);
        if (deep)
        begin
            maxd = ($urandom_range(0, 2) == 0) ? STACK_DEPTH : $urandom_range(20, STACK_DEPTH);
            target = maxd;
        end
        else
        begin
            maxd = $urandom_range(2, 5);
            target = $urandom_range(1, 6);
        end
        d = 0;
        pushed = 0;
        prev_num = 0;
        send_blanks($urandom_range(0, 1));
        while (pushed < target || d > 1)
        begin
            if (d >= 2 && (pushed >= target || d >= maxd || (!deep && $urandom_range(0, 2) == 0)))
            begin
                send_operator();
                d--;
                prev_num = 0;
                send_blanks($urandom_range(0, 2));
            end
            else
            begin
                if (prev_num)
                    send_blanks($urandom_range(1, 2));
                send_number();
                d++;
                pushed++;
                prev_num = 1;
            end
        end
        send_blanks($urandom_range(0, 2));
        send_char(CH_NL);
    endtask

    function automatic bit is_known(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_TAB ||
               c == CH_VT || c == CH_FF || c == CH_CR || c == CH_NL ||
               c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
    endfunction

    // The block only recovers through reset, so exactly one fault is sent,
    // picked at random, followed by characters that must all be ignored.
    task automatic send_fault();
        logic [2:0] kind;
        logic [7:0] c;
        kind = 3'($urandom_range(1, 5));
        case (kind)
            ST_INVALID:
                if ($urandom_range(0, 1))
                    send_text("1 2\n");
                else
                    send_char(CH_NL);
            ST_ZERODIV:
                if ($urandom_range(0, 1))
                    send_text("5 0/");
                else
                    send_text("0/");        // zero top, nothing beneath
            ST_UNKNOWN:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (is_known(c));
                send_text("3 4");
                send_char(c);
            end
            ST_UNDER:
                if ($urandom_range(0, 1))
                    send_char(CH_PLUS);
                else
                    send_text("3-");
            default:
                // one number more than the stack holds; the blank that ends
                // it raises the overflow
                for (int i = 0; i <= STACK_DEPTH; i++)
                    send_text("1 ");
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pace_t pace;
        int    pace_until;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: MIN / -1, all four operators, truncation of a negative
        // quotient, every blank class
        set_pace(PACE_STEADY);
        send_text("2147483648\t0 1-/\n");
        send_text("0 7-2/3*");
        send_char(CH_CR);
        send_text("1+");
        send_char(CH_VT);
        send_char(CH_FF);
        send_char(CH_NL);

        // random lines, pacing rotates through all phases twice
        pace = PACE_STEADY;
        pace_until = sb.n_chars + RANDOM_CHARS / 8;
        while (sb.n_chars < RANDOM_CHARS)
        begin
            if (sb.n_chars >= pace_until)
            begin
                pace = (pace == PACE_BOTH) ? PACE_STEADY : pace_t'(pace + 1);
                pace_until = sb.n_chars + RANDOM_CHARS / 8;
            end
            set_pace(pace);
            send_line();
        end

        set_pace(PACE_BOTH);
        send_fault();
        for (int i = 0; i < TAIL_CHARS; i++)
            send_char(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d characters and %0d results across all pacing phases,",
                 sb.n_chars, sb.n_results);
        $display("ending in a halt with status %0d and ignored input after it.",
                 sb.halt_status);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS postfix_expression_evaluator");
        else
            $display("FAIL postfix_expression_evaluator");
        $finish;
    end

endmodule

>>> sim.f
rtl/pee_pkg.sv
rtl/pee_ctrl.sv
rtl/pee_dp.sv
rtl/postfix_expression_evaluator.sv
sim/testbench.sv
